### hw/rtl/hrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_pkg : shared types and constants of the heun radial stepper
// word widths, fixed point format, datapath commands and saturation helper
// ----------------------------------------------------------------------------
package hrs_pkg;

    localparam int WORD_W    = 48;
    localparam int FRAC_BITS = 32;
    localparam int DX_W      = WORD_W - 1;
    localparam int L_W       = 3;
    localparam int MAG_W     = WORD_W + 1;
    localparam int LO_W      = (MAG_W + 1) / 2;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int EXT_W     = WORD_W + 4;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [MAG_W-1:0]  wide_t;
    typedef logic signed [EXT_W-1:0]  ext_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_W-1){1'b0}}});

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORBITAL_L  = CFG_IDX_W'(0),
        CFG_ENERGY     = CFG_IDX_W'(1),
        CFG_STEP_DX    = CFG_IDX_W'(2),
        CFG_INWARD     = CFG_IDX_W'(3),
        CFG_START_L    = CFG_IDX_W'(4),
        CFG_START_M    = CFG_IDX_W'(5)
    } cfg_idx_t;

    typedef enum logic [3:0] {
        DP_NOP        = 4'd0,
        DP_LOAD_START = 4'd1,
        DP_CAPTURE    = 4'd2,
        DP_MUL_RR     = 4'd3,
        DP_DV         = 4'd4,
        DP_MUL_AB     = 4'd5,
        DP_MUL_AL     = 4'd6,
        DP_WK         = 4'd7,
        DP_F          = 4'd8,
        DP_MUL_DXF0   = 4'd9,
        DP_MT         = 4'd10,
        DP_MUL_DXMM   = 4'd11,
        DP_LN         = 4'd12,
        DP_MUL_DXFF   = 4'd13,
        DP_MN         = 4'd14
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   phase;
    } hrs_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic first;
    } hrs_sts_t;

    typedef struct packed {
        logic  clip;
        word_t val;
    } sat_res_t;

    // clip an extended value into the word range
    function automatic sat_res_t sat_word(input ext_t v);
        logic [EXT_W-WORD_W:0] hi;
        sat_res_t              res;
        hi       = v[EXT_W-1:WORD_W-1];
        res.clip = (hi != '0) && (hi != '1);
        if (!res.clip)
        begin
            res.val = v[WORD_W-1:0];
        end
        else if (v[EXT_W-1])
        begin
            res.val = WORD_MIN;
        end
        else
        begin
            res.val = WORD_MAX;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/hrs_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_in_if : grid point channel
// valid/ready channel carrying one grid point per transaction
// ----------------------------------------------------------------------------
interface hrs_in_if;
    logic          valid;
    logic          ready;
    hrs_pkg::word_t radius;
    hrs_pkg::word_t potential;
    logic          first_point;
    logic          last_point;

    modport source (output valid, output radius, output potential,
                    output first_point, output last_point, input ready);
    modport sink   (input valid, input radius, input potential,
                    input first_point, input last_point, output ready);
endinterface
`default_nettype wire

### hw/rtl/hrs_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_out_if : step result channel
// valid/ready channel carrying the new l and m values per transaction
// ----------------------------------------------------------------------------
interface hrs_out_if;
    logic           valid;
    logic           ready;
    hrs_pkg::word_t next_l;
    hrs_pkg::word_t next_m;
    logic           is_last;
    logic           saturated;

    modport source (output valid, output next_l, output next_m,
                    output is_last, output saturated, input ready);
    modport sink   (input valid, input next_l, input next_m,
                    input is_last, input saturated, output ready);
endinterface
`default_nettype wire

### hw/rtl/hrs_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_mul : multi-cycle fixed point multiplier
// sign-magnitude product from four 25x25 partial products, then round,
// shift by the fraction width (or one more) and clip to the word range
// ----------------------------------------------------------------------------
module hrs_mul
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           shift_one,
    input  wire hrs_pkg::wide_t op_a,
    input  wire hrs_pkg::wide_t op_b,
    output logic                done,
    output hrs_pkg::word_t      result,
    output logic                clip
);

    logic                              busy_reg;
    logic [2:0]                        cnt_reg;
    logic                              neg_reg;
    logic                              shift_one_reg;
    logic [hrs_pkg::MAG_W-1:0]         ua_reg;
    logic [hrs_pkg::MAG_W-1:0]         ub_reg;
    logic [hrs_pkg::PROD_W-1:0]        acc_reg;

    logic [hrs_pkg::MAG_W-1:0]         ua_in;
    logic [hrs_pkg::MAG_W-1:0]         ub_in;
    logic [hrs_pkg::PROD_W-1:0]        round_in;
    logic [hrs_pkg::LO_W-1:0]          a_part;
    logic [hrs_pkg::LO_W-1:0]          b_part;
    logic [2*hrs_pkg::LO_W-1:0]        pp;
    logic [hrs_pkg::PROD_W-1:0]        pp_sh0;
    logic [hrs_pkg::PROD_W-1:0]        pp_sh1;
    logic [hrs_pkg::PROD_W-1:0]        shifted;
    logic [hrs_pkg::PROD_W-1:0]        limit;
    logic                              over;
    logic [hrs_pkg::WORD_W-1:0]        mag;

    // magnitudes of the operands
    assign ua_in = op_a[hrs_pkg::MAG_W-1] ? (~op_a + 1'b1) : op_a;
    assign ub_in = op_b[hrs_pkg::MAG_W-1] ? (~op_b + 1'b1) : op_b;

    // rounding constant, half an lsb of the result
    assign round_in = shift_one ? (hrs_pkg::PROD_W'(1) << hrs_pkg::FRAC_BITS)
                                : (hrs_pkg::PROD_W'(1) << (hrs_pkg::FRAC_BITS - 1));

    // counter bit 1 picks the half of a, bit 0 the half of b
    assign a_part = cnt_reg[1] ? hrs_pkg::LO_W'(ua_reg >> hrs_pkg::LO_W)
                               : ua_reg[hrs_pkg::LO_W-1:0];
    assign b_part = cnt_reg[0] ? hrs_pkg::LO_W'(ub_reg >> hrs_pkg::LO_W)
                               : ub_reg[hrs_pkg::LO_W-1:0];
    assign pp     = a_part * b_part;
    assign pp_sh0 = cnt_reg[0] ? (hrs_pkg::PROD_W'(pp) << hrs_pkg::LO_W)
                               : hrs_pkg::PROD_W'(pp);
    assign pp_sh1 = cnt_reg[1] ? (pp_sh0 << hrs_pkg::LO_W) : pp_sh0;

    // final scaling and clip
    assign shifted = shift_one_reg ? (acc_reg >> (hrs_pkg::FRAC_BITS + 1))
                                   : (acc_reg >> hrs_pkg::FRAC_BITS);
    assign limit   = neg_reg ? (hrs_pkg::PROD_W'(1) << (hrs_pkg::WORD_W - 1))
                             : ((hrs_pkg::PROD_W'(1) << (hrs_pkg::WORD_W - 1)) - 1'b1);
    assign over    = shifted > limit;
    assign mag     = over ? limit[hrs_pkg::WORD_W-1:0] : shifted[hrs_pkg::WORD_W-1:0];
    assign result  = $signed(neg_reg ? (~mag + 1'b1) : mag);
    assign done    = busy_reg & cnt_reg[2];
    assign clip    = done & over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg[2])
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg        <= ua_in;
            ub_reg        <= ub_in;
            neg_reg       <= op_a[hrs_pkg::MAG_W-1] ^ op_b[hrs_pkg::MAG_W-1];
            shift_one_reg <= shift_one;
            acc_reg       <= round_in;
        end
        else if (busy_reg && !cnt_reg[2])
        begin
            acc_reg <= acc_reg + pp_sh1;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/hrs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_dp : stepper datapath
// configuration and state registers, saturating alu and shared multiplier
// ----------------------------------------------------------------------------
module hrs_dp
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [hrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hrs_pkg::WORD_W-1:0]      cfg_data,
    input  wire hrs_pkg::word_t                  radius,
    input  wire hrs_pkg::word_t                  potential,
    input  wire logic                            first_point,
    input  wire logic                            last_point,
    input  wire hrs_pkg::hrs_cmd_t               cmd,
    output hrs_pkg::hrs_sts_t                    sts,
    output hrs_pkg::word_t                       next_l,
    output hrs_pkg::word_t                       next_m,
    output logic                                 is_last,
    output logic                                 saturated
);

    // configuration
    logic [hrs_pkg::L_W-1:0]  orbital_l_reg;
    hrs_pkg::word_t           energy_reg;
    logic [hrs_pkg::DX_W-1:0] step_dx_reg;
    logic                     inward_reg;
    hrs_pkg::word_t           start_l_reg;
    hrs_pkg::word_t           start_m_reg;

    // sweep state
    hrs_pkg::word_t           r0_reg;
    hrs_pkg::word_t           v0_reg;
    hrs_pkg::word_t           l_reg;
    hrs_pkg::word_t           m_reg;

    // working registers of one step
    hrs_pkg::word_t           r1_reg;
    hrs_pkg::word_t           v1_reg;
    logic                     last_reg;
    hrs_pkg::word_t           tmp_a_reg;
    hrs_pkg::word_t           tmp_b_reg;
    hrs_pkg::word_t           f0_reg;
    hrs_pkg::word_t           mt_reg;
    hrs_pkg::word_t           ln_reg;
    logic                     sat_reg;
    logic                     sat_next;

    // result registers
    hrs_pkg::word_t           next_l_reg;
    hrs_pkg::word_t           next_m_reg;
    logic                     is_last_reg;
    logic                     saturated_reg;

    hrs_pkg::word_t           d_m;
    hrs_pkg::word_t           d_r;
    hrs_pkg::word_t           d_v;
    hrs_pkg::word_t           d_l;
    hrs_pkg::wide_t           dx_w;
    hrs_pkg::ext_t            km_ext;
    hrs_pkg::sat_res_t        res_a;
    hrs_pkg::sat_res_t        res_b;
    logic                     alu_clip;

    logic                     mul_start;
    logic                     mul_shift_one;
    hrs_pkg::wide_t           mul_a;
    hrs_pkg::wide_t           mul_b;
    logic                     mul_done;
    hrs_pkg::word_t           mul_res;
    logic                     mul_clip;

    hrs_mul u_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mul_start),
        .shift_one (mul_shift_one),
        .op_a      (mul_a),
        .op_b      (mul_b),
        .done      (mul_done),
        .result    (mul_res),
        .clip      (mul_clip)
    );

    // derivative operands: stored point in the first half, new point in the second
    assign d_m  = cmd.phase ? mt_reg : m_reg;
    assign d_r  = cmd.phase ? r1_reg : r0_reg;
    assign d_v  = cmd.phase ? v1_reg : v0_reg;
    assign d_l  = cmd.phase ? ln_reg : l_reg;
    assign dx_w = $signed(hrs_pkg::MAG_W'(step_dx_reg));

    // k*m with k = 2l+1 as shift and add
    assign km_ext = hrs_pkg::ext_t'(d_m)
                  + (orbital_l_reg[0] ? (hrs_pkg::ext_t'(d_m) <<< 1) : hrs_pkg::ext_t'(0))
                  + (orbital_l_reg[1] ? (hrs_pkg::ext_t'(d_m) <<< 2) : hrs_pkg::ext_t'(0))
                  + (orbital_l_reg[2] ? (hrs_pkg::ext_t'(d_m) <<< 3) : hrs_pkg::ext_t'(0));

    always_comb
    begin
        mul_start     = 1'b0;
        mul_shift_one = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        res_a         = '0;
        res_b         = '0;
        case (cmd.op)
            hrs_pkg::DP_MUL_RR:
            begin
                mul_start = 1'b1;
                mul_a     = hrs_pkg::wide_t'(d_r);
                mul_b     = hrs_pkg::wide_t'(d_r);
            end
            hrs_pkg::DP_MUL_AB:
            begin
                mul_start = 1'b1;
                mul_a     = hrs_pkg::wide_t'(tmp_a_reg);
                mul_b     = hrs_pkg::wide_t'(tmp_b_reg);
            end
            hrs_pkg::DP_MUL_AL:
            begin
                mul_start = 1'b1;
                mul_a     = hrs_pkg::wide_t'(tmp_a_reg);
                mul_b     = hrs_pkg::wide_t'(d_l);
            end
            hrs_pkg::DP_MUL_DXF0:
            begin
                mul_start = 1'b1;
                mul_a     = dx_w;
                mul_b     = hrs_pkg::wide_t'(f0_reg);
            end
            hrs_pkg::DP_MUL_DXMM:
            begin
                mul_start     = 1'b1;
                mul_shift_one = 1'b1;
                mul_a         = dx_w;
                mul_b         = hrs_pkg::wide_t'(m_reg) + hrs_pkg::wide_t'(mt_reg);
            end
            hrs_pkg::DP_MUL_DXFF:
            begin
                mul_start     = 1'b1;
                mul_shift_one = 1'b1;
                mul_a         = dx_w;
                mul_b         = hrs_pkg::wide_t'(f0_reg) + hrs_pkg::wide_t'(tmp_b_reg);
            end
            hrs_pkg::DP_DV:
            begin
                res_a = hrs_pkg::sat_word(hrs_pkg::ext_t'(d_v) - hrs_pkg::ext_t'(energy_reg));
            end
            hrs_pkg::DP_WK:
            begin
                res_a = hrs_pkg::sat_word(hrs_pkg::ext_t'(tmp_a_reg) <<< 1);
                res_b = hrs_pkg::sat_word(km_ext);
            end
            hrs_pkg::DP_F:
            begin
                res_a = hrs_pkg::sat_word(hrs_pkg::ext_t'(tmp_a_reg)
                                        - hrs_pkg::ext_t'(tmp_b_reg));
            end
            hrs_pkg::DP_MT:
            begin
                res_a = hrs_pkg::sat_word(hrs_pkg::ext_t'(m_reg)
                                        + hrs_pkg::ext_t'(tmp_a_reg));
            end
            hrs_pkg::DP_LN:
            begin
                res_a = hrs_pkg::sat_word(inward_reg
                    ? hrs_pkg::ext_t'(l_reg) - hrs_pkg::ext_t'(tmp_a_reg)
                    : hrs_pkg::ext_t'(l_reg) + hrs_pkg::ext_t'(tmp_a_reg));
            end
            hrs_pkg::DP_MN:
            begin
                res_a = hrs_pkg::sat_word(inward_reg
                    ? hrs_pkg::ext_t'(m_reg) - hrs_pkg::ext_t'(tmp_a_reg)
                    : hrs_pkg::ext_t'(m_reg) + hrs_pkg::ext_t'(tmp_a_reg));
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign alu_clip = res_a.clip | res_b.clip;
    assign sat_next = (cmd.op == hrs_pkg::DP_CAPTURE) ? 1'b0
                    : (sat_reg | alu_clip | mul_clip);

    // configuration and sweep state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orbital_l_reg <= '0;
            energy_reg    <= '0;
            step_dx_reg   <= '0;
            inward_reg    <= 1'b0;
            start_l_reg   <= '0;
            start_m_reg   <= '0;
            r0_reg        <= '0;
            v0_reg        <= '0;
            l_reg         <= '0;
            m_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    hrs_pkg::CFG_ORBITAL_L: orbital_l_reg <= cfg_data[hrs_pkg::L_W-1:0];
                    hrs_pkg::CFG_ENERGY:    energy_reg    <= $signed(cfg_data);
                    hrs_pkg::CFG_STEP_DX:   step_dx_reg   <= cfg_data[hrs_pkg::DX_W-1:0];
                    hrs_pkg::CFG_INWARD:    inward_reg    <= cfg_data[0];
                    hrs_pkg::CFG_START_L:   start_l_reg   <= $signed(cfg_data);
                    hrs_pkg::CFG_START_M:   start_m_reg   <= $signed(cfg_data);
                    default:                inward_reg    <= inward_reg;
                endcase
            end
            if (cmd.op == hrs_pkg::DP_LOAD_START)
            begin
                r0_reg <= radius;
                v0_reg <= potential;
                l_reg  <= start_l_reg;
                m_reg  <= start_m_reg;
            end
            else if (cmd.op == hrs_pkg::DP_MN)
            begin
                r0_reg <= r1_reg;
                v0_reg <= v1_reg;
                l_reg  <= ln_reg;
                m_reg  <= res_a.val;
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        sat_reg <= sat_next;
        if (mul_done)
        begin
            tmp_a_reg <= mul_res;
        end
        case (cmd.op)
            hrs_pkg::DP_CAPTURE:
            begin
                r1_reg   <= radius;
                v1_reg   <= potential;
                last_reg <= last_point;
            end
            hrs_pkg::DP_DV:
            begin
                tmp_b_reg <= res_a.val;
            end
            hrs_pkg::DP_WK:
            begin
                tmp_a_reg <= res_a.val;
                tmp_b_reg <= res_b.val;
            end
            hrs_pkg::DP_F:
            begin
                tmp_b_reg <= res_a.val;
                if (!cmd.phase)
                begin
                    f0_reg <= res_a.val;
                end
            end
            hrs_pkg::DP_MT:
            begin
                mt_reg <= res_a.val;
            end
            hrs_pkg::DP_LN:
            begin
                ln_reg <= res_a.val;
            end
            hrs_pkg::DP_MN:
            begin
                next_l_reg    <= ln_reg;
                next_m_reg    <= res_a.val;
                is_last_reg   <= last_reg;
                saturated_reg <= sat_next;
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign sts.mul_done = mul_done;
    assign sts.first    = first_point;
    assign next_l       = next_l_reg;
    assign next_m       = next_m_reg;
    assign is_last      = is_last_reg;
    assign saturated    = saturated_reg;

endmodule
`default_nettype wire

### hw/rtl/hrs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrs_ctrl : stepper sequencer
// walks the heun step one operation at a time and owns both handshakes
// ----------------------------------------------------------------------------
module hrs_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire hrs_pkg::hrs_sts_t sts,
    output hrs_pkg::hrs_cmd_t      cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_MRR    = 14'h0002,
        S_DV     = 14'h0004,
        S_MAB    = 14'h0008,
        S_MAL    = 14'h0010,
        S_WK     = 14'h0020,
        S_F      = 14'h0040,
        S_MDXF0  = 14'h0080,
        S_MT     = 14'h0100,
        S_MDXMM  = 14'h0200,
        S_LN     = 14'h0400,
        S_MDXFF  = 14'h0800,
        S_MN     = 14'h1000,
        S_MWAIT  = 14'h2000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t ret_reg;
    state_t ret_next;
    logic   phase_reg;
    logic   phase_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.op         = hrs_pkg::DP_NOP;
        cmd.phase      = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.first)
                    begin
                        cmd.op = hrs_pkg::DP_LOAD_START;
                    end
                    else
                    begin
                        cmd.op     = hrs_pkg::DP_CAPTURE;
                        phase_next = 1'b0;
                        state_next = S_MRR;
                    end
                end
            end
            S_MRR:
            begin
                cmd.op     = hrs_pkg::DP_MUL_RR;
                ret_next   = S_DV;
                state_next = S_MWAIT;
            end
            S_DV:
            begin
                cmd.op     = hrs_pkg::DP_DV;
                state_next = S_MAB;
            end
            S_MAB:
            begin
                cmd.op     = hrs_pkg::DP_MUL_AB;
                ret_next   = S_MAL;
                state_next = S_MWAIT;
            end
            S_MAL:
            begin
                cmd.op     = hrs_pkg::DP_MUL_AL;
                ret_next   = S_WK;
                state_next = S_MWAIT;
            end
            S_WK:
            begin
                cmd.op     = hrs_pkg::DP_WK;
                state_next = S_F;
            end
            S_F:
            begin
                cmd.op     = hrs_pkg::DP_F;
                state_next = phase_reg ? S_MDXFF : S_MDXF0;
            end
            S_MDXF0:
            begin
                cmd.op     = hrs_pkg::DP_MUL_DXF0;
                ret_next   = S_MT;
                state_next = S_MWAIT;
            end
            S_MT:
            begin
                cmd.op     = hrs_pkg::DP_MT;
                state_next = S_MDXMM;
            end
            S_MDXMM:
            begin
                cmd.op     = hrs_pkg::DP_MUL_DXMM;
                ret_next   = S_LN;
                state_next = S_MWAIT;
            end
            S_LN:
            begin
                cmd.op     = hrs_pkg::DP_LN;
                phase_next = 1'b1;
                state_next = S_MRR;
            end
            S_MDXFF:
            begin
                cmd.op     = hrs_pkg::DP_MUL_DXFF;
                ret_next   = S_MN;
                state_next = S_MWAIT;
            end
            S_MN:
            begin
                // commit only once the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = hrs_pkg::DP_MN;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MWAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/heun_radial_ode_stepper.sv
`default_nettype none
// a stepping point is accepted only while the sequencer is idle, so no new point is taken
// until its step is committed; a start point is taken every cycle while the sequencer is idle
// a step runs nine products through one shared multiplier (each from four 25x25
// partial products) plus nine saturating alu steps
// reset: asynchronous active-low rst_n clears the sequencer, all configuration
// registers and the stored point, l and m to zero; no clearing pass is needed
// ----------------------------------------------------------------------------
// heun_radial_ode_stepper : modified euler stepper for the radial wave pair
// integrates l' = m, m' = -(2l+1)m + 2r^2(v-e)l in saturating fixed point
// ----------------------------------------------------------------------------
module heun_radial_ode_stepper
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [hrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [hrs_pkg::WORD_W-1:0]    cfg_data,
    hrs_in_if.sink                             points,
    hrs_out_if.source                          results
);

    // command and status between sequencer and datapath
    hrs_pkg::hrs_cmd_t cmd;
    hrs_pkg::hrs_sts_t sts;

    // sequencer: owns the input and output handshakes and issues one
    // datapath operation per state; multiplies park in a common wait state
    hrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (points.valid),
        .in_ready  (points.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: configuration, sweep state, alu, multiplier and the
    // result register, which lets the next point in while a result waits
    hrs_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .radius      (points.radius),
        .potential   (points.potential),
        .first_point (points.first_point),
        .last_point  (points.last_point),
        .cmd         (cmd),
        .sts         (sts),
        .next_l      (results.next_l),
        .next_m      (results.next_m),
        .is_last     (results.is_last),
        .saturated   (results.saturated)
    );

endmodule
`default_nettype wire
